### src/rne_pkg.sv
// Package with the shared constants, codes and lookup functions of the Roman numeral encoder.
package rne_pkg;

   // Widths of the payload fields.
   localparam int ValueWidth  = 16;
   localparam int SymbolWidth = 7;
   localparam int DigitWidth  = 4;

   // The extraction sequence runs one compare and subtract per step.
   localparam int NumSteps   = 15;
   localparam int StepWidth  = 4;
   // The first steps only remove multiples of ten thousand.
   localparam int SkipSteps  = 3;
   localparam int QuotWidth  = 3 * DigitWidth;

   // Symbol sent with an empty run.
   localparam logic [SymbolWidth-1:0] SymbolNone = 7'd0;

   // Roman letter kind within one decimal place.
   typedef enum logic [1:0] {
      CODE_NONE = 2'd0,
      CODE_ONE  = 2'd1,
      CODE_FIVE = 2'd2,
      CODE_TEN  = 2'd3
   } code_type;

   // Weight subtracted at each extraction step: binary-weighted decimal places.
   function automatic logic [ValueWidth-1:0] step_weight(input logic [StepWidth-1:0] step);
      logic [ValueWidth-1:0] w;
      begin
         unique case (step)
            4'd0:    w = 16'd40000;
            4'd1:    w = 16'd20000;
            4'd2:    w = 16'd10000;
            4'd3:    w = 16'd8000;
            4'd4:    w = 16'd4000;
            4'd5:    w = 16'd2000;
            4'd6:    w = 16'd1000;
            4'd7:    w = 16'd800;
            4'd8:    w = 16'd400;
            4'd9:    w = 16'd200;
            4'd10:   w = 16'd100;
            4'd11:   w = 16'd80;
            4'd12:   w = 16'd40;
            4'd13:   w = 16'd20;
            4'd14:   w = 16'd10;
            default: w = 16'd0;
         endcase
         return w;
      end
   endfunction

   // Letter pattern of one decimal digit, position idx within the run.
   function automatic code_type digit_code(input logic [DigitWidth-1:0] digit,
                                           input logic [1:0] idx);
      code_type c;
      begin
         c = CODE_NONE;
         unique case (digit)
            4'd1: c = (idx == 2'd0) ? CODE_ONE : CODE_NONE;
            4'd2: c = (idx <= 2'd1) ? CODE_ONE : CODE_NONE;
            4'd3: c = (idx <= 2'd2) ? CODE_ONE : CODE_NONE;
            4'd4: c = (idx == 2'd0) ? CODE_ONE : ((idx == 2'd1) ? CODE_FIVE : CODE_NONE);
            4'd5: c = (idx == 2'd0) ? CODE_FIVE : CODE_NONE;
            4'd6: c = (idx == 2'd0) ? CODE_FIVE : ((idx == 2'd1) ? CODE_ONE : CODE_NONE);
            4'd7: c = (idx == 2'd0) ? CODE_FIVE : ((idx <= 2'd2) ? CODE_ONE : CODE_NONE);
            4'd8: c = (idx == 2'd0) ? CODE_FIVE : CODE_ONE;
            4'd9: c = (idx == 2'd0) ? CODE_ONE : ((idx == 2'd1) ? CODE_TEN : CODE_NONE);
            default: c = CODE_NONE;
         endcase
         return c;
      end
   endfunction

   // ASCII letter for a code at a decimal place (0 units .. 3 thousands).
   function automatic logic [SymbolWidth-1:0] place_letter(input logic [1:0] place,
                                                          input code_type code);
      logic [SymbolWidth-1:0] s;
      begin
         s = SymbolNone;
         unique case (place)
            2'd0: s = (code == CODE_ONE) ? 7'h49 : ((code == CODE_FIVE) ? 7'h56 : 7'h58);
            2'd1: s = (code == CODE_ONE) ? 7'h58 : ((code == CODE_FIVE) ? 7'h4C : 7'h43);
            2'd2: s = (code == CODE_ONE) ? 7'h43 : ((code == CODE_FIVE) ? 7'h44 : 7'h4D);
            default: s = 7'h4D;
         endcase
         if (code == CODE_NONE) begin
            s = SymbolNone;
         end
         return s;
      end
   endfunction

endpackage

### src/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: digit extraction and character sequencer.
//
// Usage: drive req_value and pulse start while busy is low; that edge is the
// input transfer. The block then stays busy while it works on the number.
// It first extracts the decimal digits with one shared compare and subtract
// unit, one step per cycle (three steps drop multiples of ten thousand, then
// four binary-weighted steps per place for thousands, hundreds and tens; the
// remainder is the units digit).
// It then sends the Roman numeral, most significant letter first, one
// character per cycle on rsp_symbol, marked by rsp_strobe, with rsp_last on
// the final character. A place without letters ahead of the final letter
// leaves a gap with no character. A number that gives no letters yields one
// transfer with rsp_empty_res and rsp_last high and rsp_symbol zero.
// Busy drops in the cycle that shows the last result, so the next input
// transfer can already come in that cycle. The receiver cannot stall: each
// result is valid for one cycle only.
// Reset (synchronous, active high) returns the block to idle and clears
// the strobe.
module roman_numeral_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [rne_pkg::ValueWidth-1:0]     req_value,
   output logic                               rsp_strobe,
   output logic [rne_pkg::SymbolWidth-1:0]    rsp_symbol,
   output logic                               rsp_last,
   output logic                               rsp_empty_res
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXTRACT,
      ST_EMIT
   } state_type;

   state_type                           state_ff, state_in;
   logic [rne_pkg::StepWidth-1:0]       step_ff, step_in;
   logic [rne_pkg::ValueWidth-1:0]      rem_ff, rem_in;
   logic [rne_pkg::QuotWidth-1:0]       quot_ff, quot_in;
   logic [1:0]                          place_ff, place_in;
   logic [1:0]                          idx_ff, idx_in;
   logic                                strobe_ff, strobe_in;
   logic [rne_pkg::SymbolWidth-1:0]     symbol_ff, symbol_in;
   logic                                last_ff, last_in;
   logic                                empty_ff, empty_in;

   logic [rne_pkg::ValueWidth-1:0]      weight;
   logic                                ge;
   logic [rne_pkg::ValueWidth-1:0]      diff;
   logic [rne_pkg::DigitWidth-1:0]      digit_eff [4];
   logic [rne_pkg::DigitWidth-1:0]      thousands;
   logic [rne_pkg::DigitWidth-1:0]      cur_digit;
   rne_pkg::code_type                   code;
   rne_pkg::code_type                   next_code;
   logic                                lower_nz;
   logic                                all_zero;

   // Shared compare and subtract unit.
   always_comb begin
      weight = rne_pkg::step_weight(step_ff);
      ge     = (rem_ff >= weight);
      diff   = rem_ff - weight;
   end

   // Digits as they stand after extraction; a thousands digit above three gives nothing.
   always_comb begin
      thousands    = quot_ff[3*rne_pkg::DigitWidth-1:2*rne_pkg::DigitWidth];
      digit_eff[3] = ((thousands >= 4'd1) && (thousands <= 4'd3)) ? thousands : 4'd0;
      digit_eff[2] = quot_ff[2*rne_pkg::DigitWidth-1:rne_pkg::DigitWidth];
      digit_eff[1] = quot_ff[rne_pkg::DigitWidth-1:0];
      digit_eff[0] = rem_ff[rne_pkg::DigitWidth-1:0];
   end

   // Letter lookup for the current place and position, plus lookahead for the last flag.
   always_comb begin
      cur_digit = digit_eff[place_ff];
      code      = rne_pkg::digit_code(cur_digit, idx_ff);
      next_code = (idx_ff == 2'd3) ? rne_pkg::CODE_NONE
                                   : rne_pkg::digit_code(cur_digit, idx_ff + 2'd1);
      lower_nz  = 1'b0;
      for (int q = 0; q < 4; q++) begin
         if ((q < int'(place_ff)) && (digit_eff[q] != 4'd0)) begin
            lower_nz = 1'b1;
         end
      end
      all_zero = (digit_eff[0] == 4'd0) && (digit_eff[1] == 4'd0) &&
                 (digit_eff[2] == 4'd0) && (digit_eff[3] == 4'd0);
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      place_in  = place_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      empty_in  = empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXTRACT;
               step_in  = '0;
               rem_in   = req_value;
               quot_in  = '0;
            end
         end
         ST_EXTRACT: begin
            if (ge) begin
               rem_in = diff;
            end
            if (step_ff >= rne_pkg::StepWidth'(rne_pkg::SkipSteps)) begin
               quot_in = {quot_ff[rne_pkg::QuotWidth-2:0], ge};
            end
            step_in = step_ff + rne_pkg::StepWidth'(1);
            if (step_ff == rne_pkg::StepWidth'(rne_pkg::NumSteps - 1)) begin
               state_in = ST_EMIT;
               place_in = 2'd3;
               idx_in   = 2'd0;
            end
         end
         ST_EMIT: begin
            if (all_zero) begin
               // Nothing to send: one empty transfer.
               strobe_in = 1'b1;
               symbol_in = rne_pkg::SymbolNone;
               last_in   = 1'b1;
               empty_in  = 1'b1;
               state_in  = ST_IDLE;
            end else if (code == rne_pkg::CODE_NONE) begin
               // Digit gives no letters: move to the next lower place, or go idle at the units.
               if (place_ff == 2'd0) begin
                  state_in = ST_IDLE;
               end else begin
                  place_in = place_ff - 2'd1;
                  idx_in   = 2'd0;
               end
            end else begin
               strobe_in = 1'b1;
               symbol_in = rne_pkg::place_letter(place_ff, code);
               last_in   = (next_code == rne_pkg::CODE_NONE) && !lower_nz;
               empty_in  = 1'b0;
               if ((next_code == rne_pkg::CODE_NONE) && !lower_nz) begin
                  state_in = ST_IDLE;
               end else if (next_code == rne_pkg::CODE_NONE) begin
                  place_in = place_ff - 2'd1;
                  idx_in   = 2'd0;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      place_ff  <= place_in;
      idx_ff    <= idx_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_symbol    = symbol_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;

   // A result only follows a cycle in which the block was working.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result transfer without work in progress");

   // The empty transfer carries no letter and ends the run.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_empty_res) |-> (rsp_last && (rsp_symbol == rne_pkg::SymbolNone)))
      else $error("malformed empty result");

   // The final character frees the block for the next number.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("block still busy after the last character");

   // An accepted number makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("input transfer did not start work");

endmodule
